@@ hw/rtl/wsfhp_pkg.sv @@
// Package for the WebSocket frame header parser.
// Holds the parse phase and event codes, the length constants and the result record.
// It has no dependencies. Every module of the parser but wsfhp_in_stage uses it.
package wsfhp_pkg;

  // Parse phases, one-hot encoded.
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXT_HI  = 6'b000100,
    PH_EXT_LO  = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER_BYTE = 2'd0,
    EV_HEADER_DONE = 2'd1,
    EV_PAYLOAD     = 2'd2,
    EV_ERROR       = 2'd3
  } event_kind_t;

  localparam logic [6:0]  LEN_EXT16 = 7'h7E;
  localparam logic [15:0] KEY_BYTES = 16'd4;

  typedef struct packed {
    event_kind_t kind;
    logic        frame_done;
    logic        final_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [15:0] payload_length;
    logic [31:0] masking_key;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

@@ hw/rtl/websocket_frame_header_parser_unit.sv @@
// WebSocket frame header parser, one stream byte in and one event out per request.
//
// Input channel: byte_valid / byte_stall carry stream_byte, one raw byte of the stream.
// Output channel: event_valid / event_stall carry one event per input byte: its kind
// (header byte, header complete, payload byte, unsupported length), a frame-done mark,
// the current frame's FIN, opcode, MASK, length and masking key, and the raw payload byte.
// Payload bytes are passed through masked, exactly as received.
//
// An accepted byte waits in the input register while the decode step runs, and the result
// register loads its event once it is empty or its event is being taken. Throughput is one
// byte per clock while the receiver does not stall; the frame state is updated in the same
// cycle that a byte moves from the input register to the result register.
//
// Reset (rst, synchronous) empties both registers and sets the parser to expect the
// first byte of a new frame header with all held fields zero.
// When the receiver stalls, the result register holds its event, the input register
// keeps one more byte, and after that byte_stall is raised until the event is taken.
module websocket_frame_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  stream_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic        frame_done,
  output logic        final_flag,
  output logic [3:0]  frame_opcode,
  output logic        masked_flag,
  output logic [15:0] payload_length,
  output logic [31:0] masking_key,
  output logic [7:0]  payload_byte
);

  logic               held_valid;
  logic [7:0]         held_byte;
  logic               load_ready;
  logic               take;
  wsfhp_pkg::result_t step_result;
  wsfhp_pkg::result_t out_result;

  assign take = held_valid && load_ready;

  wsfhp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .stream_byte (stream_byte),
    .take        (take),
    .held_valid  (held_valid),
    .held_byte   (held_byte)
  );

  wsfhp_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (held_byte),
    .result      (step_result)
  );

  wsfhp_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (held_valid),
    .load_ready  (load_ready),
    .load_result (step_result),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .held_result (out_result)
  );

  assign event_kind     = out_result.kind;
  assign frame_done     = out_result.frame_done;
  assign final_flag     = out_result.final_flag;
  assign frame_opcode   = out_result.frame_opcode;
  assign masked_flag    = out_result.masked_flag;
  assign payload_length = out_result.payload_length;
  assign masking_key    = out_result.masking_key;
  assign payload_byte   = out_result.payload_byte;

endmodule

@@ hw/rtl/wsfhp_in_stage.sv @@
// Input register of the WebSocket frame header parser.
// Holds one stream byte until the decode step takes it. It depends on no package items.
module wsfhp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] stream_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid;
  logic [7:0] data;

  // The register refills in the same cycle that the held byte moves on.
  assign byte_stall = valid && !take;
  assign held_valid = valid;
  assign held_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!byte_stall) begin
      valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      data <= stream_byte;
    end
  end

endmodule

@@ hw/rtl/wsfhp_decoder.sv @@
// Decode step of the WebSocket frame header parser: the running frame state
// and the logic that turns one byte into one result. Uses wsfhp_pkg.
module wsfhp_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        stream_byte,
  output wsfhp_pkg::result_t result
);

  wsfhp_pkg::phase_t phase, phase_next;
  logic [15:0] countdown, countdown_next;
  logic [15:0] length, length_next;
  logic [31:0] key, key_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask, mask_next;
  logic [15:0] count_dec;
  logic        len_known;
  wsfhp_pkg::event_kind_t kind;
  logic        done;
  logic [7:0]  pbyte;

  assign count_dec = countdown - 16'd1;

  always_comb begin
    phase_next     = phase;
    countdown_next = countdown;
    length_next    = length;
    key_next       = key;
    fin_next       = fin;
    opcode_next    = opcode;
    mask_next      = mask;
    kind           = wsfhp_pkg::EV_HEADER_BYTE;
    done           = 1'b0;
    pbyte          = 8'd0;
    len_known      = 1'b0;

    case (phase)
      wsfhp_pkg::PH_SECOND: begin
        mask_next = stream_byte[7];
        if (stream_byte[6:0] < wsfhp_pkg::LEN_EXT16) begin
          length_next = {9'd0, stream_byte[6:0]};
          len_known   = 1'b1;
        end else if (stream_byte[6:0] == wsfhp_pkg::LEN_EXT16) begin
          length_next = 16'd0;
          phase_next  = wsfhp_pkg::PH_EXT_HI;
        end else begin
          // A 64-bit length is not supported: report and resync on a new header.
          length_next = 16'd0;
          kind        = wsfhp_pkg::EV_ERROR;
          done        = 1'b1;
          phase_next  = wsfhp_pkg::PH_FIRST;
        end
      end
      wsfhp_pkg::PH_EXT_HI: begin
        length_next = {stream_byte, 8'd0};
        phase_next  = wsfhp_pkg::PH_EXT_LO;
      end
      wsfhp_pkg::PH_EXT_LO: begin
        length_next = {length[15:8], stream_byte};
        len_known   = 1'b1;
      end
      wsfhp_pkg::PH_KEY: begin
        key_next       = {key[23:0], stream_byte};
        countdown_next = count_dec;
        if (count_dec == 16'd0) begin
          kind = wsfhp_pkg::EV_HEADER_DONE;
          if (length == 16'd0) begin
            phase_next = wsfhp_pkg::PH_FIRST;
            done       = 1'b1;
          end else begin
            phase_next     = wsfhp_pkg::PH_PAYLOAD;
            countdown_next = length;
          end
        end
      end
      wsfhp_pkg::PH_PAYLOAD: begin
        kind           = wsfhp_pkg::EV_PAYLOAD;
        pbyte          = stream_byte;
        countdown_next = count_dec;
        if (count_dec == 16'd0) begin
          done       = 1'b1;
          phase_next = wsfhp_pkg::PH_FIRST;
        end
      end
      default: begin
        fin_next       = stream_byte[7];
        opcode_next    = stream_byte[3:0];
        mask_next      = 1'b0;
        length_next    = 16'd0;
        key_next       = 32'd0;
        countdown_next = 16'd0;
        phase_next     = wsfhp_pkg::PH_SECOND;
      end
    endcase

    // Once the length is known, either the key follows or the header is complete.
    if (len_known) begin
      if (mask_next) begin
        phase_next     = wsfhp_pkg::PH_KEY;
        countdown_next = wsfhp_pkg::KEY_BYTES;
      end else begin
        kind = wsfhp_pkg::EV_HEADER_DONE;
        if (length_next == 16'd0) begin
          phase_next = wsfhp_pkg::PH_FIRST;
          done       = 1'b1;
        end else begin
          phase_next     = wsfhp_pkg::PH_PAYLOAD;
          countdown_next = length_next;
        end
      end
    end
  end

  always_comb begin
    result.kind           = kind;
    result.frame_done     = done;
    result.final_flag     = fin_next;
    result.frame_opcode   = opcode_next;
    result.masked_flag    = mask_next;
    result.payload_length = length_next;
    result.masking_key    = key_next;
    result.payload_byte   = pbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsfhp_pkg::PH_FIRST;
      countdown <= 16'd0;
      length    <= 16'd0;
      key       <= 32'd0;
      fin       <= 1'b0;
      opcode    <= 4'd0;
      mask      <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      countdown <= countdown_next;
      length    <= length_next;
      key       <= key_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      mask      <= mask_next;
    end
  end

endmodule

@@ hw/rtl/wsfhp_out_stage.sv @@
// Result register of the WebSocket frame header parser.
// Holds one result until the receiver takes it. Uses wsfhp_pkg for the result record.
module wsfhp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  wsfhp_pkg::result_t load_result,
  output logic               event_valid,
  input  logic               event_stall,
  output wsfhp_pkg::result_t held_result
);

  logic               valid;
  wsfhp_pkg::result_t data;

  assign load_ready  = !valid || !event_stall;
  assign event_valid = valid;
  assign held_result = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data <= load_result;
    end
  end

endmodule

@@ tb/ws_event_checker.sv @@
// Event checker for the WebSocket frame header parser.
// Watches both request channels, predicts each event and compares it field by field.
// Depends on wsfhp_pkg for the phase and event codes and the result record.
`timescale 1ns / 100ps

module ws_event_checker
  import wsfhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  stream_byte,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [1:0]  event_kind,
  input  logic        frame_done,
  input  logic        final_flag,
  input  logic [3:0]  frame_opcode,
  input  logic        masked_flag,
  input  logic [15:0] payload_length,
  input  logic [31:0] masking_key,
  input  logic [7:0]  payload_byte,
  output int          errors,
  output int          pending
);

  // Predicted frame state.
  phase_t      phase;
  logic [15:0] countdown;
  logic [15:0] frame_len;
  logic [31:0] frame_key;
  logic        frame_fin;
  logic [3:0]  frame_op;
  logic        frame_mask;

  result_t expected_events[$];
  result_t want;
  result_t got;

  task automatic close_length(output event_kind_t kind, output logic done);
    done = 1'b0;
    if (frame_mask) begin
      phase = PH_KEY;
      countdown = KEY_BYTES;
      kind = EV_HEADER_BYTE;
    end else begin
      kind = EV_HEADER_DONE;
      if (frame_len == 16'd0) begin
        phase = PH_FIRST;
        done = 1'b1;
      end else begin
        phase = PH_PAYLOAD;
        countdown = frame_len;
      end
    end
  endtask

  task automatic decode_stream_byte(input logic [7:0] b, output result_t r);
    event_kind_t kind;
    logic        done;
    logic [7:0]  raw;
    kind = EV_HEADER_BYTE;
    done = 1'b0;
    raw = 8'd0;
    case (phase)
      PH_SECOND: begin
        frame_mask = b[7];
        if (b[6:0] < LEN_EXT16) begin
          frame_len = {9'd0, b[6:0]};
          close_length(kind, done);
        end else if (b[6:0] == LEN_EXT16) begin
          frame_len = 16'd0;
          phase = PH_EXT_HI;
        end else begin
          // 64-bit lengths are not supported: report and wait for a new header.
          frame_len = 16'd0;
          kind = EV_ERROR;
          done = 1'b1;
          phase = PH_FIRST;
        end
      end
      PH_EXT_HI: begin
        frame_len = {b, 8'd0};
        phase = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        frame_len[7:0] = b;
        close_length(kind, done);
      end
      PH_KEY: begin
        frame_key = {frame_key[23:0], b};
        countdown = countdown - 16'd1;
        if (countdown == 16'd0) begin
          kind = EV_HEADER_DONE;
          if (frame_len == 16'd0) begin
            phase = PH_FIRST;
            done = 1'b1;
          end else begin
            phase = PH_PAYLOAD;
            countdown = frame_len;
          end
        end
      end
      PH_PAYLOAD: begin
        kind = EV_PAYLOAD;
        raw = b;
        countdown = countdown - 16'd1;
        if (countdown == 16'd0) begin
          done = 1'b1;
          phase = PH_FIRST;
        end
      end
      default: begin
        // First header byte; the reserved bits 6..4 are dropped.
        frame_fin = b[7];
        frame_op = b[3:0];
        frame_mask = 1'b0;
        frame_len = 16'd0;
        frame_key = 32'd0;
        countdown = 16'd0;
        phase = PH_SECOND;
      end
    endcase
    r.kind = kind;
    r.frame_done = done;
    r.final_flag = frame_fin;
    r.frame_opcode = frame_op;
    r.masked_flag = frame_mask;
    r.payload_length = frame_len;
    r.masking_key = frame_key;
    r.payload_byte = raw;
  endtask

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_FIRST;
      countdown = 16'd0;
      frame_len = 16'd0;
      frame_key = 32'd0;
      frame_fin = 1'b0;
      frame_op = 4'd0;
      frame_mask = 1'b0;
      expected_events.delete();
    end else begin
      if (event_valid && !event_stall) begin
        got.kind = event_kind_t'(event_kind);
        got.frame_done = frame_done;
        got.final_flag = final_flag;
        got.frame_opcode = frame_opcode;
        got.masked_flag = masked_flag;
        got.payload_length = payload_length;
        got.masking_key = masking_key;
        got.payload_byte = payload_byte;
        if (expected_events.size() == 0) begin
          $display("%0t: event with none expected, expected nothing, got %h", $time, got);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.kind, event_kind);
          check_field("frame_done", want.frame_done, frame_done);
          check_field("final_flag", want.final_flag, final_flag);
          check_field("frame_opcode", want.frame_opcode, frame_opcode);
          check_field("masked_flag", want.masked_flag, masked_flag);
          check_field("payload_length", want.payload_length, payload_length);
          check_field("masking_key", want.masking_key, masking_key);
          check_field("payload_byte", want.payload_byte, payload_byte);
        end
      end
      if (byte_valid && !byte_stall) begin
        decode_stream_byte(stream_byte, want);
        expected_events.push_back(want);
      end
    end
    pending = expected_events.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench for websocket_frame_header_parser_unit.
// Drives directed and random frame streams with random gaps and receiver stalls.
// Depends on wsfhp_pkg and on ws_event_checker, which predicts and compares.
`timescale 1ns / 100ps

module testbench;
  import wsfhp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int STREAM_BYTES = 1800;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  stream_byte = 8'd0;
  logic        event_valid;
  logic        event_stall = 1'b0;
  logic [1:0]  event_kind;
  logic        frame_done;
  logic        final_flag;
  logic [3:0]  frame_opcode;
  logic        masked_flag;
  logic [15:0] payload_length;
  logic [31:0] masking_key;
  logic [7:0]  payload_byte;

  int errors;
  int pending;
  int cycles = 0;
  int stall_left = 0;
  int sent = 0;
  bit calm = 1'b0;

  websocket_frame_header_parser_unit u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .stream_byte(stream_byte),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind(event_kind),
    .frame_done(frame_done),
    .final_flag(final_flag),
    .frame_opcode(frame_opcode),
    .masked_flag(masked_flag),
    .payload_length(payload_length),
    .masking_key(masking_key),
    .payload_byte(payload_byte)
  );

  ws_event_checker u_checker (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .stream_byte(stream_byte),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind(event_kind),
    .frame_done(frame_done),
    .final_flag(final_flag),
    .frame_opcode(frame_opcode),
    .masked_flag(masked_flag),
    .payload_length(payload_length),
    .masking_key(masking_key),
    .payload_byte(payload_byte),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      event_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      event_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    n = pick_gap();
    repeat (n) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent++;
  endtask

  // Holds off the sender until every request has produced its event.
  task automatic drain_events();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_frame();
    logic [7:0] first;
    logic [7:0] ext_hi;
    logic [7:0] ext_lo;
    bit         mask;
    bit         ext;
    int         len;
    int         r;
    first = $urandom_range(0, 255);
    mask = $urandom_range(0, 1);
    ext = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // Unsupported 64-bit length: the frame stops after its second byte.
      send_byte(first);
      send_byte({mask, 7'h7F});
      return;
    end else if (r < 40) begin
      ext = 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        ext_hi = 8'd1;
        ext_lo = $urandom_range(0, 255);
      end else begin
        ext_hi = 8'd0;
        ext_lo = $urandom_range(0, 24);
      end
    end
    if (ext) begin
      len = {ext_hi, ext_lo};
    end else if (r < 43) begin
      len = 125;
    end else begin
      len = $urandom_range(0, 12);
    end
    send_byte(first);
    if (ext) begin
      send_byte({mask, 7'h7E});
      send_byte(ext_hi);
      send_byte(ext_lo);
    end else begin
      send_byte({mask, len[6:0]});
    end
    if (mask) repeat (4) send_byte($urandom_range(0, 255));
    repeat (len) send_byte($urandom_range(0, 255));
  endtask

  logic [7:0] opening [25] = '{
    8'hFF, 8'h00,                                        // empty frame, all first-byte bits set
    8'h00, 8'h7F,                                        // unsupported length
    8'h81, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A, // masked, zero extended length
    8'h82, 8'h02, 8'hFF, 8'h00,                          // short unmasked payload
    8'h8A, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hAB,     // masked one-byte payload
    8'h09, 8'hFF                                         // unsupported length with mask set
  };

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i]);
    drain_events();

    while (sent < STREAM_BYTES) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 49) == 0) drain_events();
      send_frame();
    end

    drain_events();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
